FILE: hw/rtl/idrm_pkg.sv
package idrm_pkg;

	localparam int unsigned DEF_MAP_ENTRIES = 32;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	localparam logic SEL_USER  = 1'b0;
	localparam logic SEL_GROUP = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	localparam logic [31:0] OVERFLOW_ID = 32'd65534;

	typedef struct packed {
		logic        command;
		logic        map_select;
		logic [31:0] id_value;
		logic [31:0] outside_start;
		logic [31:0] range_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] translated_id;
	} rsp_t;

	// stored form of one range: [base, upper) maps to id + delta
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] upper;
		logic [31:0] delta;
	} entry_t;

	// lookup that walks down the row of cells
	typedef struct packed {
		logic        valid;
		logic        sel;
		logic        found;
		logic [31:0] id;
		logic [31:0] xlat;
	} token_t;

	// per-cell write strobes and entry-in-use flags
	typedef struct packed {
		logic wr_user;
		logic wr_group;
		logic used_user;
		logic used_group;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/idrm_cell.sv
module idrm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  idrm_pkg::cell_ctl_t ctl,
	input  idrm_pkg::entry_t   wr_entry,
	input  idrm_pkg::token_t   tok_in,
	output idrm_pkg::token_t   tok_out
);
	import idrm_pkg::*;

	entry_t user_q;
	entry_t group_q;
	entry_t cur;
	logic   in_use;
	logic   hit;
	token_t tok_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_user) begin
			user_q <= wr_entry;
		end
		if (ctl.wr_group) begin
			group_q <= wr_entry;
		end
	end

	always_comb begin
		cur    = (tok_in.sel == SEL_GROUP) ? group_q : user_q;
		in_use = (tok_in.sel == SEL_GROUP) ? ctl.used_group : ctl.used_user;
		hit    = in_use && (tok_in.id >= cur.base) && (tok_in.id < cur.upper);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.sel   <= tok_in.sel;
			tok_q.id    <= tok_in.id;
			tok_q.found <= tok_in.found | hit;
			// first match wins
			tok_q.xlat  <= tok_in.found ? tok_in.xlat : tok_in.id + cur.delta;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: hw/rtl/id_range_map_translator.sv
// Id range map translator: two range tables (user ids, group ids) and a
// lookup that walks them.
//
// Command port: an item transfers at a rising edge with start high and busy
// low. request.command selects add (append a range to the table picked by
// map_select) or translate (map id_value through that table).
// Result port: done is high for exactly one cycle with response valid; the
// receiver cannot stall, so each result must be taken in that cycle.
//
// Add: result in the cycle after the transfer; busy stays low, so back-to-back
// adds run at one per cycle. A full table answers ST_FULL, nothing written.
// Translate: the lookup token passes one cell per cycle through a row of
// MAP_ENTRIES cells, each holding one user and one group entry. The result
// is registered once the token leaves the last cell; busy is high while the
// token is in the row, so no new command is taken until the lookup is through.
// Reset clears both used counts and the row; entry contents need no reset
// since only entries below the used count ever take part in a match.
module id_range_map_translator #(
	parameter int unsigned MAP_ENTRIES = idrm_pkg::DEF_MAP_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  idrm_pkg::req_t request,
	output logic          done,
	output idrm_pkg::rsp_t response
);
	import idrm_pkg::*;

	localparam int unsigned UW = $clog2(MAP_ENTRIES + 1);

	logic [UW-1:0] user_used_q;
	logic [UW-1:0] group_used_q;
	logic          scan_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          take;
	logic          do_add;
	logic          do_xlat;
	logic          tbl_full;
	entry_t        new_entry;
	token_t        tok [MAP_ENTRIES+1];
	token_t        tok_last;

	assign take     = start && !busy;
	assign do_add   = take && (request.command == CMD_ADD);
	assign do_xlat  = take && (request.command == CMD_XLATE);
	assign tbl_full = (request.map_select == SEL_GROUP) ?
		(group_used_q == UW'(MAP_ENTRIES)) : (user_used_q == UW'(MAP_ENTRIES));

	// store the range as [base, base+count) and outside-base, so each
	// cell needs only two compares and one add (all mod 2^32)
	always_comb begin
		new_entry.base  = request.id_value;
		new_entry.upper = request.id_value + request.range_count;
		new_entry.delta = request.outside_start - request.id_value;
	end

	// lookup token entering the first cell
	always_comb begin
		tok[0].valid = do_xlat;
		tok[0].sel   = request.map_select;
		tok[0].found = 1'b0;
		tok[0].id    = request.id_value;
		tok[0].xlat  = '0;
	end

	for (genvar i = 0; i < MAP_ENTRIES; i++) begin : g_cell
		cell_ctl_t ctl;

		always_comb begin
			ctl.wr_user    = do_add && !tbl_full && (request.map_select == SEL_USER) &&
				(user_used_q == UW'(i));
			ctl.wr_group   = do_add && !tbl_full && (request.map_select == SEL_GROUP) &&
				(group_used_q == UW'(i));
			ctl.used_user  = (UW'(i) < user_used_q);
			ctl.used_group = (UW'(i) < group_used_q);
		end

		idrm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_entry (new_entry),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	assign tok_last = tok[MAP_ENTRIES];

	// used counts; no adds happen while a lookup is in the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_used_q  <= '0;
			group_used_q <= '0;
		end else if (do_add && !tbl_full) begin
			if (request.map_select == SEL_GROUP) begin
				group_used_q <= group_used_q + UW'(1);
			end else begin
				user_used_q <= user_used_q + UW'(1);
			end
		end
	end

	// busy from translate transfer until the token leaves the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
		end else if (do_xlat) begin
			scan_q <= 1'b1;
		end else if (tok_last.valid) begin
			scan_q <= 1'b0;
		end
	end

	assign busy = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= do_add || tok_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			rsp_q.status        <= tbl_full ? ST_FULL : ST_OK;
			rsp_q.translated_id <= '0;
		end else if (tok_last.valid) begin
			rsp_q.status        <= tok_last.found ? ST_OK : ST_NOMATCH;
			rsp_q.translated_id <= tok_last.found ? tok_last.xlat : OVERFLOW_ID;
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

FILE: tb/id_range_map_check.sv
module id_range_map_check #(
	parameter int unsigned MAP_ENTRIES = idrm_pkg::DEF_MAP_ENTRIES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  idrm_pkg::req_t request,
	input  logic           done,
	input  idrm_pkg::rsp_t response,
	output int unsigned    mismatch_count,
	output int unsigned    responses_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import idrm_pkg::*;

	localparam int unsigned SHOWN_MISMATCHES = 10;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] outside;
		logic [31:0] count;
	} id_range_t;

	// [0] user ids, [1] group ids
	id_range_t   ranges [2][MAP_ENTRIES];
	int unsigned ranges_used [2];
	rsp_t        owed_q [$];

	// Updates the shadow tables and returns the response the command earns.
	function automatic rsp_t apply_request(req_t r);
		rsp_t        res;
		int unsigned t;
		int unsigned i;
		logic [31:0] upper;
		t = (r.map_select == SEL_GROUP) ? 1 : 0;
		if (r.command == CMD_ADD) begin
			res.translated_id = '0;
			if (ranges_used[t] >= MAP_ENTRIES) begin
				res.status = ST_FULL;
			end else begin
				ranges[t][ranges_used[t]] = '{base: r.id_value,
					outside: r.outside_start, count: r.range_count};
				ranges_used[t]++;
				res.status = ST_OK;
			end
			return res;
		end
		// first hit wins; upper end wraps mod 2^32
		for (i = 0; i < ranges_used[t]; i++) begin
			upper = ranges[t][i].base + ranges[t][i].count;
			if (r.id_value >= ranges[t][i].base && r.id_value < upper) begin
				res.status        = ST_OK;
				res.translated_id = ranges[t][i].outside
					+ (r.id_value - ranges[t][i].base);
				return res;
			end
		end
		res.status        = ST_NOMATCH;
		res.translated_id = OVERFLOW_ID;
		return res;
	endfunction

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			ranges_used    = '{0, 0};
			owed_q.delete();
			mismatch_count = 0;
		end else begin
			// result leaves before the same-edge transfer joins the queue
			if (done === 1'b1) begin
				if (owed_q.size() == 0) begin
					note_mismatch($sformatf("result with none pending: status %0d id %h",
						response.status, response.translated_id));
				end else begin
					want = owed_q.pop_front();
					if (response.status !== want.status)
						note_mismatch($sformatf("status: expected %0d, got %0d",
							want.status, response.status));
					if (response.translated_id !== want.translated_id)
						note_mismatch($sformatf("translated_id: expected %h, got %h",
							want.translated_id, response.translated_id));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				owed_q.push_back(apply_request(request));
		end
		responses_owed = owed_q.size();
	end

endmodule

FILE: tb/id_range_map_translator_test.sv
module id_range_map_translator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import idrm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1100;
	// last stretch runs with start held high between transfers
	localparam int unsigned CALM_TAIL    = 150;
	// limit covers the slowest legal run: about 1125 items, each a translate after the longest pause
	localparam int unsigned CYCLE_LIMIT  = 400_000;
	// room for a translate to pass the whole row after its transfer
	localparam int unsigned DRAIN_CYCLES = DEF_MAP_ENTRIES + 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	req_t        request;
	rsp_t        response;
	int unsigned mismatch_count;
	int unsigned responses_owed;

	// Ranges already sent, used only to aim translates at and around them.
	// Only the first MAP_ENTRIES adds per table can ever be stored.
	logic [31:0] aim_lo  [2][DEF_MAP_ENTRIES];
	logic [31:0] aim_cnt [2][DEF_MAP_ENTRIES];
	int unsigned aim_n   [2] = '{0, 0};

	id_range_map_translator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	id_range_map_check check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.done           (done),
		.response       (response),
		.mismatch_count (mismatch_count),
		.responses_owed (responses_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the block hangs or stops answering.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic req_t make_req(logic cmd, logic sel, logic [31:0] idv,
			logic [31:0] osv, logic [31:0] cnt);
		req_t r;
		r.command       = cmd;
		r.map_select    = sel;
		r.id_value      = idv;
		r.outside_start = osv;
		r.range_count   = cnt;
		return r;
	endfunction

	// Drive at the falling edge, then hold until a rising edge sees busy low.
	// start stays high afterwards; the next transfer or a pause decides it.
	task automatic send(req_t item);
		int unsigned t;
		t = (item.map_select == SEL_GROUP) ? 1 : 0;
		@(negedge clk);
		start   <= 1'b1;
		request <= item;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		if (item.command == CMD_ADD && aim_n[t] < DEF_MAP_ENTRIES) begin
			aim_lo[t][aim_n[t]]  = item.id_value;
			aim_cnt[t][aim_n[t]] = item.range_count;
			aim_n[t]++;
		end
	endtask

	// Idle burst; junk on the request bus must be ignored.
	task automatic pause(int unsigned n);
		@(negedge clk);
		start   <= 1'b0;
		request <= make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom, $urandom, $urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic add_range(logic sel, logic [31:0] lo, logic [31:0] osv,
			logic [31:0] cnt);
		send(make_req(CMD_ADD, sel, lo, osv, cnt));
	endtask

	// unused fields carry random values on a translate
	task automatic translate(logic sel, logic [31:0] idv);
		send(make_req(CMD_XLATE, sel, idv, $urandom, $urandom));
	endtask

	// Adds: mostly small, disjoint-ish ranges so translates hit; some zero
	// counts, some full-width values, and ranges near the top that may wrap.
	function automatic req_t random_add();
		logic [31:0] lo;
		logic [31:0] cnt;
		case ($urandom_range(0, 19))
			0, 1: begin
				lo  = $urandom;
				cnt = '0;
			end
			2, 3, 4: begin
				lo  = $urandom;
				cnt = $urandom;
			end
			5, 6, 7: begin
				lo  = 32'hFFFF_FFFF - $urandom_range(0, 20000);
				cnt = $urandom_range(1, 40000);
			end
			default: begin
				lo  = $urandom_range(0, 200000);
				cnt = $urandom_range(1, 3000);
			end
		endcase
		return make_req(CMD_ADD, 1'($urandom_range(0, 1)), lo, $urandom, cnt);
	endfunction

	// Translates: mostly aimed inside or at the edges of a stored range,
	// the rest random over the full id space or the small-id region.
	function automatic req_t random_xlate();
		int unsigned t;
		int unsigned k;
		logic [31:0] lo;
		logic [31:0] cnt;
		logic [31:0] idv;
		t = $urandom_range(0, 1);
		if (aim_n[t] != 0 && $urandom_range(0, 9) < 7) begin
			k   = $urandom_range(0, aim_n[t] - 1);
			lo  = aim_lo[t][k];
			cnt = aim_cnt[t][k];
			case ($urandom_range(0, 7))
				0: idv = lo;
				1: idv = lo + cnt - 1;
				2: idv = lo + cnt;
				3: idv = lo - 1;
				default: idv = (cnt == 0) ? lo : lo + ($urandom % cnt);
			endcase
		end else if ($urandom_range(0, 1)) begin
			idv = $urandom;
		end else begin
			idv = $urandom_range(0, 200000);
		end
		return make_req(CMD_XLATE, t[0], idv, $urandom, $urandom);
	endfunction

	initial begin
		int unsigned i;
		int unsigned idle_pct;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		idle_pct = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, back to back.
		// lookups on empty tables miss
		translate(SEL_USER, 32'h0000_0000);
		translate(SEL_GROUP, 32'hFFFF_FFFF);
		// overlapping ranges: first one stored wins on the overlap
		add_range(SEL_USER, 32'd100, 32'd1000, 32'd10);
		add_range(SEL_USER, 32'd105, 32'd5000, 32'd100);
		// zero count: stored, never matches
		add_range(SEL_USER, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
		// end wraps past the top: never matches
		add_range(SEL_USER, 32'hFFFF_FFF0, 32'h0000_0000, 32'h20);
		// ends exactly at the top; outside sum wraps
		add_range(SEL_USER, 32'hFFFF_FF00, 32'hFFFF_FFF0, 32'hFF);
		// nearly the whole id space
		add_range(SEL_GROUP, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		translate(SEL_USER, 32'd100);
		translate(SEL_USER, 32'd109);
		translate(SEL_USER, 32'd110);
		translate(SEL_USER, 32'd99);
		translate(SEL_USER, 32'h0000_0000);
		translate(SEL_USER, 32'hFFFF_FFF5);
		translate(SEL_USER, 32'hFFFF_FFFE);
		translate(SEL_USER, 32'hFFFF_FFFF);
		translate(SEL_GROUP, 32'h0000_0000);
		translate(SEL_GROUP, 32'hFFFF_FFFE);
		translate(SEL_GROUP, 32'hFFFF_FFFF);
		// unused fields at all ones on a translate
		send(make_req(CMD_XLATE, SEL_GROUP, 32'd12345, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		// Random part. Roughly one in eight is an add, so both tables fill
		// about halfway through and the rest also exercises the full-table
		// answer and lookups across all entries. Idle density changes every
		// 64 items, including stretches with none.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			if (i + CALM_TAIL < RANDOM_ITEMS && $urandom_range(1, 100) <= idle_pct)
				pause($urandom_range(1, 7));
			if ($urandom_range(0, 99) < 12)
				send(random_add());
			else
				send(random_xlate());
		end
		@(negedge clk);
		start <= 1'b0;

		// drain, then leave room for any stray extra result
		while (responses_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && responses_owed == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
